// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: rtl/nfa_pkg.sv
package nfa_pkg;

    // Automaton sizing.
    localparam int MAX_STATES = 16;
    localparam int MAX_EDGES  = 64;

    // Field widths fixed by the request and result formats.
    localparam int CMD_W   = 3;
    localparam int STATE_W = 4;
    localparam int SYM_W   = 8;
    localparam int EDGE_W  = STATE_W + SYM_W + STATE_W;

    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_EDGE  = 3'd0,
        CMD_SET_FINAL = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_START     = 3'd3,
        CMD_FEED      = 3'd4
    } cmd_t;

    typedef logic [MAX_STATES-1:0] state_set_t;

    // Write port of the edge table.
    typedef struct packed {
        logic               we;
        logic [EDGE_AW-1:0] addr;
        logic [EDGE_W-1:0]  data;
    } edge_wr_t;

    // Scan launch from the controller.
    typedef struct packed {
        logic             start;
        logic [SYM_W-1:0] symbol;
        state_set_t       active;
        logic [CNT_W-1:0] count;
    } scan_req_t;

    // Scan completion back to the controller.
    typedef struct packed {
        logic       done;
        state_set_t next_set;
    } scan_rsp_t;

    // True when the state index names a state of the automaton.
    function automatic logic state_ok(input logic [STATE_W-1:0] idx);
        return 32'(idx) < MAX_STATES;
    endfunction

    // One-hot set holding only the given state (empty if out of range).
    function automatic state_set_t state_bit(input logic [STATE_W-1:0] idx);
        state_set_t d;
        for (int i = 0; i < MAX_STATES; i++) begin
            d[i] = (32'(idx) == i);
        end
        return d;
    endfunction

    // Membership test of one state in a set.
    function automatic logic set_has(input state_set_t set, input logic [STATE_W-1:0] idx);
        return |(set & state_bit(idx));
    endfunction

endpackage

// File: rtl/nfa_string_matcher.sv
// Results: the result of every command but feed symbol is registered and appears in the
// cycle after the request is taken; a feed symbol first runs a scan (which reads nothing
// with an empty table), as the scan reads one stored edge per cycle, then registers its result.
// Throughput: one request per cycle for commands other than feed symbol while results are
// taken; a feed symbol holds off the next request until its result is out or taken.
// Reset (aresetn low at a clock edge): only state 0 active, no final states, empty edge
// table, no result pending. No clearing pass is needed.
`include "assert_macros.svh"

module nfa_string_matcher
    import nfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[2:0], source_state[6:3], symbol[14:7], target_state[18:15], final_flag[19]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0], dead[1], status[2]
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    state_set_t       active_reg;
    state_set_t       final_reg;
    logic [CNT_W-1:0] count_reg;
    logic             m_tvalid_reg;
    logic             accepted_reg;
    logic             dead_reg;
    logic             status_reg;

    state_set_t       active_next;
    state_set_t       final_next;
    logic [CNT_W-1:0] count_next;
    logic             status_next;

    logic               accept;
    cmd_t               cmd;
    logic [STATE_W-1:0] src;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] dst;
    logic               flag;

    edge_wr_t  wr;
    scan_req_t req;
    scan_rsp_t rsp;

    // Request field decode.
    assign cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
    assign src  = s_tdata[CMD_W +: STATE_W];
    assign sym  = s_tdata[CMD_W+STATE_W +: SYM_W];
    assign dst  = s_tdata[CMD_W+STATE_W+SYM_W +: STATE_W];
    assign flag = s_tdata[CMD_W+2*STATE_W+SYM_W];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Commands other than feed symbol, and table writes.
    always_comb begin
        active_next = active_reg;
        final_next  = final_reg;
        count_next  = count_reg;
        status_next = 1'b0;
        wr.we       = 1'b0;
        wr.addr     = count_reg[EDGE_AW-1:0];
        wr.data     = {src, sym, dst};
        unique case (cmd)
            CMD_ADD_EDGE: begin
                if (state_ok(src) && state_ok(dst)) begin
                    if (32'(count_reg) >= MAX_EDGES) begin
                        status_next = 1'b1;
                    end else begin
                        wr.we      = accept;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            CMD_SET_FINAL: begin
                if (flag) begin
                    final_next = final_reg | state_bit(src);
                end else begin
                    final_next = final_reg & ~state_bit(src);
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            CMD_START: begin
                active_next = state_set_t'(1);
            end
            default: begin
            end
        endcase
    end

    // Scan launch.
    assign req.start  = accept && (cmd == CMD_FEED);
    assign req.symbol = sym;
    assign req.active = active_reg;
    assign req.count  = count_reg;

    nfa_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .req     (req),
        .rsp     (rsp)
    );

    // Controller state, automaton state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= state_set_t'(1);
            final_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (cmd != CMD_FEED)) begin
                        active_reg   <= active_next;
                        final_reg    <= final_next;
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        accepted_reg <= |(active_next & final_next);
                        dead_reg     <= (active_next == '0);
                        status_reg   <= status_next;
                    end else begin
                        if (accept) begin
                            state_reg <= ST_SCAN;
                        end
                        if (m_tready) begin
                            m_tvalid_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (rsp.done) begin
                        state_reg    <= ST_IDLE;
                        active_reg   <= rsp.next_set;
                        m_tvalid_reg <= 1'b1;
                        accepted_reg <= |(rsp.next_set & final_reg);
                        dead_reg     <= (rsp.next_set == '0);
                        status_reg   <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-3)'(0), status_reg, dead_reg, accepted_reg};

    `ASSERT_NEVER(a_no_req_in_scan, aclk, aresetn, (state_reg == ST_SCAN) && s_tready)
    `ASSERT_NEVER(a_count_bound, aclk, aresetn, 32'(count_reg) > MAX_EDGES)
    `ASSERT_IMPLIES(a_no_result_in_scan, aclk, aresetn, state_reg == ST_SCAN, !m_tvalid_reg)
    `ASSERT_NEXT(a_feed_starts_scan, aclk, aresetn, req.start, state_reg == ST_SCAN)

endmodule

// File: rtl/nfa_scan.sv
`include "assert_macros.svh"

module nfa_scan
    import nfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  edge_wr_t  wr,
    input  scan_req_t req,
    output scan_rsp_t rsp
);

    // Edge table: source in the top bits, then symbol, then target.
    logic [EDGE_W-1:0] mem [MAX_EDGES];
    logic [EDGE_W-1:0] rd_data_reg;

    logic               busy_reg;
    logic               issue_reg;
    logic               rd_valid_reg;
    logic [EDGE_AW-1:0] idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SYM_W-1:0]   sym_reg;
    state_set_t         active_reg;
    state_set_t         acc_reg;

    logic               idx_last;
    logic               match;
    logic               done;
    logic [STATE_W-1:0] rd_src;
    logic [SYM_W-1:0]   rd_sym;
    logic [STATE_W-1:0] rd_dst;

    // Table write and registered read.
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (issue_reg) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Compare the fetched edge against the active set and the fed symbol.
    assign rd_src   = rd_data_reg[EDGE_W-1 -: STATE_W];
    assign rd_sym   = rd_data_reg[STATE_W +: SYM_W];
    assign rd_dst   = rd_data_reg[STATE_W-1:0];
    assign match    = rd_valid_reg && set_has(active_reg, rd_src) && (rd_sym == sym_reg);
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign done     = busy_reg && !issue_reg && !rd_valid_reg;

    // Sequencer: one table address per cycle, accumulate the next set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end else if (req.start) begin
            busy_reg     <= 1'b1;
            issue_reg    <= (req.count != '0);
            rd_valid_reg <= 1'b0;
            idx_reg      <= '0;
            count_reg    <= req.count;
            sym_reg      <= req.symbol;
            active_reg   <= req.active;
            acc_reg      <= '0;
        end else if (busy_reg) begin
            rd_valid_reg <= issue_reg;
            if (issue_reg) begin
                idx_reg <= idx_reg + EDGE_AW'(1);
                if (idx_last) begin
                    issue_reg <= 1'b0;
                end
            end
            if (match) begin
                acc_reg <= acc_reg | state_bit(rd_dst);
            end
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done;
    assign rsp.next_set = acc_reg;

    `ASSERT_IMPLIES(a_issue_busy, aclk, aresetn, issue_reg, busy_reg)
    `ASSERT_IMPLIES(a_read_busy, aclk, aresetn, rd_valid_reg, busy_reg)
    `ASSERT_NEXT(a_done_ends, aclk, aresetn, done && !req.start, !busy_reg)

endmodule
